@@ hw/rtl/sfgt_pkg.sv @@
// types, codes and constants shared by the serial frame gap transceiver
package sfgt_pkg;

  localparam int unsigned BufferDepthDefault = 256;
  localparam int unsigned QueueDepth         = 2;
  localparam logic [7:0]  GapTicksReset      = 8'd4;

  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_RX_BYTE    = 3'd1,
    REQ_TX_SLOT    = 3'd2,
    REQ_START_RX   = 3'd3,
    REQ_START_TX   = 3'd4,
    REQ_BUF_WR     = 3'd5,
    REQ_BUF_RD     = 3'd6,
    REQ_LOAD_TIMER = 3'd7
  } req_type_e;

  typedef enum logic [2:0] {
    RES_NONE      = 3'd0,
    RES_FRAME     = 3'd1,
    RES_TX_BYTE   = 3'd2,
    RES_TX_DONE   = 3'd3,
    RES_READ_DATA = 3'd4
  } res_kind_e;

  typedef enum logic [1:0] {
    STAGE_IDLE  = 2'd0,
    STAGE_BUSY  = 2'd1,
    STAGE_FRAME = 2'd2
  } stage_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_WRITE = 2'd1,
    MEM_READ  = 2'd2
  } mem_op_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  byte_value;
    logic        rx_error;
    logic [7:0]  buffer_index;
    logic [8:0]  send_count;
    logic [15:0] timer_load;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  out_byte;
    logic [8:0]  frame_length;
    logic [1:0]  stage_code;
    logic        timer_expired;
    logic        rx_active;
  } out_rsp_t;

  typedef struct packed {
    mem_op_e     op;
    logic [7:0]  wdata;
    res_kind_e   result_kind;
    logic [8:0]  frame_length;
    stage_e      stage_code;
    logic        timer_expired;
    logic        rx_active;
  } cmd_t;

endpackage

@@ hw/rtl/serial_frame_gap_transceiver.sv @@
// top level of the serial frame gap transceiver
// Takes one request per clock unless stalled and returns exactly one response per
// request, in order. The front end updates all counters and flags in the cycle a
// request is accepted; the response passes the command queue and the output register.
// Sustained rate is one request per cycle unless stalled, set by the single-port
// frame buffer in the back end, which does one read or one write per cycle. A
// two-entry command queue separates the two ends, so in_stall_o rises only once the
// output has been stalled long enough to fill it. The gap register may be written at
// any time through the configuration channel, which is always ready.
module serial_frame_gap_transceiver
  import sfgt_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BufferDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_req_t    in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_rsp_t   out_rsp_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  cmd_t          push_cmd, pop_cmd;
  logic [AW-1:0] push_addr, pop_addr;
  logic          accept, pop, full, empty;

  assign accept      = in_valid_i && !full;
  assign in_stall_o  = full;
  assign cfg_ready_o = 1'b1;

  sfgt_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (in_req_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (push_cmd),
    .addr_o     (push_addr)
  );

  sfgt_queue #(
    .AW(AW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_cmd_i (push_cmd),
    .push_addr_i(push_addr),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .pop_addr_o (pop_addr),
    .full_o     (full),
    .empty_o    (empty)
  );

  sfgt_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .cmd_i      (pop_cmd),
    .addr_i     (pop_addr),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

@@ hw/rtl/sfgt_front.sv @@
// front end: request decode, control state update and buffer command issue
module sfgt_front
  import sfgt_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BufferDepthDefault,
  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  in_req_t       req_i,
  input  logic          cfg_valid_i,
  input  logic [7:0]    cfg_data_i,
  output cmd_t          cmd_o,
  output logic [AW-1:0] addr_o
);

  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned WW = (CW > 9) ? CW : 9;
  localparam logic [CW-1:0] DepthC = CW'(BUFFER_DEPTH);
  localparam logic [WW-1:0] DepthW = WW'(BUFFER_DEPTH);

  logic [7:0]    gap_ticks_q;
  logic [CW-1:0] byte_cnt_q, byte_cnt_d;
  logic [7:0]    gap_cnt_q, gap_cnt_d;
  logic [15:0]   step_timer_q, step_timer_d;
  logic [CW-1:0] send_len_q, send_len_d;
  logic          receiving_q, receiving_d;
  logic          transmitting_q, transmitting_d;
  stage_e        stage_q, stage_d;
  res_kind_e     kind;
  mem_op_e       op;
  logic [AW-1:0] addr;
  logic          idx_ok;
  logic [WW-1:0] cnt_w;

  assign idx_ok = 32'(req_i.buffer_index) < BUFFER_DEPTH;
  assign cnt_w  = WW'(req_i.send_count);

  always_comb begin
    byte_cnt_d     = byte_cnt_q;
    gap_cnt_d      = gap_cnt_q;
    step_timer_d   = step_timer_q;
    send_len_d     = send_len_q;
    receiving_d    = receiving_q;
    transmitting_d = transmitting_q;
    stage_d        = stage_q;
    kind           = RES_NONE;
    op             = MEM_NONE;
    addr           = AW'(byte_cnt_q);
    case (req_i.req_type)
      REQ_TICK: begin
        if (step_timer_q != 16'd0) begin
          step_timer_d = step_timer_q - 16'd1;
        end
        if (receiving_q) begin
          if (gap_cnt_q != 8'd0) begin
            gap_cnt_d = gap_cnt_q - 8'd1;
          end else begin
            gap_cnt_d = gap_ticks_q;
            if (byte_cnt_q != '0) begin
              receiving_d = 1'b0;
              stage_d     = STAGE_FRAME;
              kind        = RES_FRAME;
            end
          end
        end
      end
      REQ_RX_BYTE: begin
        if (receiving_q) begin
          gap_cnt_d = gap_ticks_q;
          if (!req_i.rx_error && byte_cnt_q < DepthC) begin
            op         = MEM_WRITE;
            byte_cnt_d = byte_cnt_q + CW'(1);
          end
        end
      end
      REQ_TX_SLOT: begin
        if (transmitting_q) begin
          if (byte_cnt_q < send_len_q) begin
            op         = MEM_READ;
            kind       = RES_TX_BYTE;
            byte_cnt_d = byte_cnt_q + CW'(1);
          end else begin
            transmitting_d = 1'b0;
            stage_d        = STAGE_IDLE;
            kind           = RES_TX_DONE;
          end
        end
      end
      REQ_START_RX: begin
        byte_cnt_d     = '0;
        gap_cnt_d      = gap_ticks_q;
        receiving_d    = 1'b1;
        transmitting_d = 1'b0;
        stage_d        = STAGE_BUSY;
      end
      REQ_START_TX: begin
        send_len_d     = (cnt_w > DepthW) ? DepthC : CW'(cnt_w);
        byte_cnt_d     = '0;
        transmitting_d = 1'b1;
        receiving_d    = 1'b0;
        stage_d        = STAGE_BUSY;
      end
      REQ_BUF_WR: begin
        addr = AW'(req_i.buffer_index);
        if (idx_ok) begin
          op = MEM_WRITE;
        end
      end
      REQ_BUF_RD: begin
        addr = AW'(req_i.buffer_index);
        kind = RES_READ_DATA;
        if (idx_ok) begin
          op = MEM_READ;
        end
      end
      REQ_LOAD_TIMER: begin
        step_timer_d = req_i.timer_load;
      end
      default: begin
      end
    endcase
  end

  assign cmd_o.op            = op;
  assign cmd_o.wdata         = req_i.byte_value;
  assign cmd_o.result_kind   = kind;
  assign cmd_o.frame_length  = 9'(byte_cnt_d);
  assign cmd_o.stage_code    = stage_d;
  assign cmd_o.timer_expired = (step_timer_d == 16'd0);
  assign cmd_o.rx_active     = receiving_d;
  assign addr_o              = addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q <= GapTicksReset;
    end else if (cfg_valid_i) begin
      gap_ticks_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q     <= '0;
      gap_cnt_q      <= GapTicksReset;
      step_timer_q   <= 16'd0;
      send_len_q     <= '0;
      receiving_q    <= 1'b0;
      transmitting_q <= 1'b0;
      stage_q        <= STAGE_IDLE;
    end else if (accept_i) begin
      byte_cnt_q     <= byte_cnt_d;
      gap_cnt_q      <= gap_cnt_d;
      step_timer_q   <= step_timer_d;
      send_len_q     <= send_len_d;
      receiving_q    <= receiving_d;
      transmitting_q <= transmitting_d;
      stage_q        <= stage_d;
    end
  end

endmodule

@@ hw/rtl/sfgt_queue.sv @@
// short command queue between front end and back end
module sfgt_queue
  import sfgt_pkg::*;
#(
  parameter int unsigned AW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          push_cmd_i,
  input  logic [AW-1:0] push_addr_i,
  input  logic          pop_i,
  output cmd_t          pop_cmd_o,
  output logic [AW-1:0] pop_addr_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned NW = $clog2(QueueDepth + 1);
  localparam logic [PW-1:0] LastPtr = PW'(QueueDepth - 1);

  cmd_t          cmd_q  [QueueDepth];
  logic [AW-1:0] addr_q [QueueDepth];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] count_q;

  assign full_o     = (count_q == NW'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_cmd_o  = cmd_q[rd_ptr_q];
  assign pop_addr_o = addr_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_q[wr_ptr_q]  <= push_cmd_i;
      addr_q[wr_ptr_q] <= push_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + NW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/sfgt_back.sv @@
// back end: frame buffer access and response output register
module sfgt_back
  import sfgt_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BufferDepthDefault,
  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  cmd_t          cmd_i,
  input  logic [AW-1:0] addr_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output out_rsp_t      out_rsp_o
);

  logic [7:0] mem_q [BUFFER_DEPTH];
  logic [7:0] rdata_q;
  cmd_t       meta_q;
  logic       out_valid_q;
  logic       pop;

  assign pop   = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o = pop;

  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.op == MEM_WRITE) begin
      mem_q[addr_i] <= cmd_i.wdata;
    end
    if (pop && cmd_i.op == MEM_READ) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      meta_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_rsp_o.result_kind   = meta_q.result_kind;
  assign out_rsp_o.out_byte      = (meta_q.op == MEM_READ) ? rdata_q : 8'd0;
  assign out_rsp_o.frame_length  = meta_q.frame_length;
  assign out_rsp_o.stage_code    = meta_q.stage_code;
  assign out_rsp_o.timer_expired = meta_q.timer_expired;
  assign out_rsp_o.rx_active     = meta_q.rx_active;

endmodule
